[hw/rtl/cartridge_bank_mapper_with_scanline_irq_core_macros.svh]
// Assertion helper macros for the cartridge mapper core
`ifndef CARTRIDGE_BANK_MAPPER_WITH_SCANLINE_IRQ_CORE_MACROS_SVH
`define CARTRIDGE_BANK_MAPPER_WITH_SCANLINE_IRQ_CORE_MACROS_SVH
// assert that a implies b on the next edge
`define CBM_ASSERT_NEXT(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
// assert that a implies b in the same cycle
`define CBM_ASSERT_NOW(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`endif

[hw/rtl/cbm_pkg.sv]
// ----------------------------------------------------------------------------
// cbm_pkg
// Shared types and constants of the cartridge mapper core.
// ----------------------------------------------------------------------------
package cbm_pkg;
    localparam logic [2:0] FN_CPU_WR = 3'd0;
    localparam logic [2:0] FN_RD     = 3'd1;
    localparam logic [2:0] FN_NT_RD  = 3'd2;
    localparam logic [2:0] FN_NT_WR  = 3'd3;
    localparam logic [2:0] FN_TICK   = 3'd4;

    localparam logic [2:0] TG_NONE = 3'd0;
    localparam logic [2:0] TG_PROM = 3'd1;
    localparam logic [2:0] TG_PRAM = 3'd2;
    localparam logic [2:0] TG_CHR  = 3'd3;
    localparam logic [2:0] TG_CIRAM = 3'd4;

    typedef struct packed {
        logic [2:0]  func;
        logic [15:0] addr;
        logic [7:0]  wdata;
        logic        ppu_rendering;
        logic        tall_sprites;
        logic        fetching_sprites;
        logic [8:0]  scanline;
        logic [8:0]  dot;
        logic        render_on;
        logic        irq_masked;
    } item_t;

    typedef struct packed {
        logic [7:0]  rdata;
        logic [2:0]  target;
        logic [20:0] phys_addr;
        logic        ext_write;
        logic        irq_assert;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOD,
        ST_OUT
    } exec_state_t;
endpackage

[hw/rtl/cbm_ram.sv]
// ----------------------------------------------------------------------------
// cbm_ram
// Generic RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module cbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[hw/rtl/cbm_queue.sv]
// ----------------------------------------------------------------------------
// cbm_queue
// Two-entry item queue between the input side and the execute side.
// ----------------------------------------------------------------------------
module cbm_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  cbm_pkg::item_t in_item,
    output logic          out_valid,
    input  logic          out_ready,
    output cbm_pkg::item_t out_item
);
    import cbm_pkg::*;

    item_t      slot_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_item  = slot_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wp_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

[hw/rtl/cbm_exec.sv]
// ----------------------------------------------------------------------------
// cbm_exec
// Execute side: register file, address translation, ext RAM, scanline IRQ.
// ----------------------------------------------------------------------------
module cbm_exec #(
    parameter int EXRAM_DEPTH = 1024
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [8:0]      cfg_wdata,
    input  logic            in_valid,
    output logic            in_ready,
    input  cbm_pkg::item_t  in_item,
    output logic            out_valid,
    input  logic            out_ready,
    output cbm_pkg::result_t out_res,
    output logic            clearing
);
    import cbm_pkg::*;
    localparam int XW = $clog2(EXRAM_DEPTH);

    exec_state_t state_reg, state_next;
    result_t res_reg, res_next;
    logic    res_v_reg, res_v_next;

    logic [8:0] bank_cnt_reg;
    logic [1:0] prg_mode_reg, chr_mode_reg, exram_mode_reg, chr_upper_reg;
    logic [1:0] ram_prot_reg [2];
    logic [7:0] nt_map_reg, fill_tile_reg, fill_attr_reg, irq_cmp_reg;
    logic [7:0] prg_bank_reg [5];
    logic [7:0] chr_bank_reg [12];
    logic [7:0] split_reg [3];
    logic       irq_en_reg, irq_pend_reg, in_frame_reg;
    logic [7:0] mult_a_reg, mult_b_reg, line_cnt_reg;
    logic [15:0] prod_reg;
    logic [XW:0] clr_reg;

    // modulo unit: partial remainder registered at accept
    logic [7:0] mbank_next;
    logic [7:0] mrem_reg, mrem_next;
    logic [7:0] mod_res;
    logic       mod_use_reg, mod_use_next;
    logic [14:0] moff_reg, moff_next;

    logic             ram_we;
    logic [XW-1:0]    ram_wa;
    logic [7:0]       ram_wd, ram_q;

    cbm_ram #(.WIDTH(8), .DEPTH(EXRAM_DEPTH)) u_ram (
        .clk(clk), .we(ram_we), .waddr(ram_wa), .wdata(ram_wd),
        .raddr(in_item.addr[XW-1:0]), .rdata(ram_q)
    );

    assign clearing  = !clr_reg[XW];
    assign in_ready  = (state_reg == ST_IDLE) && !res_v_reg && !clearing;
    assign out_valid = res_v_reg;
    assign out_res   = res_reg;

    // bank % count by restoring compare-subtract (bank < 256): steps 7..4 ahead
    // of the accept edge, steps 3..0 in ST_MOD. A zero count subtracts nothing.
    always_comb
    begin
        logic [16:0] r;
        r = 17'(mbank_next);
        for (int b = 7; b >= 4; b--)
        begin
            if (r >= (17'(bank_cnt_reg) << b)) r = r - (17'(bank_cnt_reg) << b);
        end
        mrem_next = r[7:0];
    end

    always_comb
    begin
        logic [16:0] r;
        r = 17'(mrem_reg);
        for (int b = 3; b >= 0; b--)
        begin
            if (r >= (17'(bank_cnt_reg) << b)) r = r - (17'(bank_cnt_reg) << b);
        end
        mod_res = r[7:0];
    end

    // decoded combinational pieces for the current item
    logic [2:0]  tg;
    logic [20:0] pa;
    logic [7:0]  rd;
    logic        wr;
    logic        rram;
    logic        frame_now;
    logic        irq_now;

    function automatic logic [20:0] chr_map(input logic [15:0] a, input logic tb,
                                            input logic [1:0] m,
                                            input logic [7:0] regs [12]);
        logic [13:0] size;
        logic [3:0]  idx;
        logic [12:0] off;
        logic [12:0] aa;
        logic [3:0]  slot;
        begin
            size = 14'h2000 >> m;
            aa   = tb ? {1'b0, a[11:0]} : a[12:0];
            slot = 4'(aa >> (13 - 32'(m)));
            off  = aa & 13'(size - 14'd1);
            if (!tb)
                idx = 4'((32'(slot) + 1) * (8 >> m) - 1);
            else if (m == 2'd0)
            begin
                idx = 4'd11;
                off = a[12:0];
            end
            else
                idx = 4'(8 + (32'(slot) + 1) * (4 >> (m - 1)) - 1);
            chr_map = 21'(regs[idx]) * 21'(size) + 21'(off);
        end
    endfunction

    function automatic logic pg_is2(input logic [15:0] a);
        pg_is2 = (2'(nt_map_reg >> {a[11:10], 1'b0}) == 2'd2);
    endfunction

    always_comb
    begin
        logic [1:0] q, pg;
        logic [2:0] idx;
        logic [1:0] lg;
        logic [7:0] v, bk;
        tg = TG_NONE; pa = '0; rd = '0; wr = 1'b0; rram = 1'b0;
        frame_now = 1'b0; irq_now = 1'b0;
        mbank_next = '0; mod_use_next = 1'b0; moff_next = moff_reg;
        q = 2'd0; pg = 2'd0; idx = 3'd0; lg = 2'd0; v = '0; bk = '0;
        case (in_item.func)
            FN_CPU_WR:
            begin
                if (in_item.addr >= 16'h6000 && in_item.addr <= 16'h7fff)
                begin
                    tg = TG_PRAM; wr = 1'b1;
                    pa = (21'(prg_bank_reg[0]) << 13) + 21'(in_item.addr - 16'h6000);
                end
            end
            FN_RD:
            begin
                if (in_item.addr == 16'h5204)
                    rd = {irq_pend_reg, in_frame_reg, 6'd0};
                else if (in_item.addr == 16'h5205)
                    rd = prod_reg[7:0];
                else if (in_item.addr == 16'h5206)
                    rd = prod_reg[15:8];
                else if (in_item.addr >= 16'h5c00 && in_item.addr <= 16'h5fff)
                    rram = (exram_mode_reg >= 2'd2);
                else if (in_item.addr >= 16'h6000 && in_item.addr <= 16'h7fff)
                begin
                    tg = TG_PRAM;
                    pa = (21'(prg_bank_reg[0]) << 13) + 21'(in_item.addr - 16'h6000);
                end
                else if (in_item.addr >= 16'h8000)
                begin
                    // lg: 0 -> 8K, 1 -> 16K, 2 -> 32K
                    case (prg_mode_reg)
                        2'd0: begin idx = 3'd4; lg = 2'd2; end
                        2'd1: begin idx = in_item.addr[14] ? 3'd4 : 3'd2; lg = 2'd1; end
                        2'd2:
                        begin
                            if (!in_item.addr[14]) begin idx = 3'd2; lg = 2'd1; end
                            else begin idx = in_item.addr[13] ? 3'd4 : 3'd3; lg = 2'd0; end
                        end
                        default: begin idx = 3'd1 + {1'b0, in_item.addr[14:13]}; lg = 2'd0; end
                    endcase
                    v  = prg_bank_reg[idx];
                    bk = v;
                    if (lg == 2'd2) bk = bk & 8'hfc;
                    else if (lg == 2'd1) bk = bk & 8'hfe;
                    case (lg)
                        2'd2:    moff_next = in_item.addr[14:0];
                        2'd1:    moff_next = {1'b0, in_item.addr[13:0]};
                        default: moff_next = {2'b0, in_item.addr[12:0]};
                    endcase
                    if (idx >= 3'd1 && idx <= 3'd3 && !v[7])
                    begin
                        tg = TG_PRAM;
                        pa = (21'(bk & 8'h0f) << 13) + 21'(moff_next);
                    end
                    else
                    begin
                        if (idx >= 3'd1 && idx <= 3'd3) bk = bk & 8'h7f;
                        tg = TG_PROM; mod_use_next = 1'b1; mbank_next = bk;
                    end
                end
                else if (in_item.addr <= 16'h1fff)
                begin
                    tg = TG_CHR;
                    pa = chr_map(in_item.addr, in_item.tall_sprites
                                 && !in_item.fetching_sprites, chr_mode_reg, chr_bank_reg);
                end
            end
            FN_NT_RD, FN_NT_WR:
            begin
                q  = in_item.addr[11:10];
                pg = 2'(nt_map_reg >> {q, 1'b0});
                if (pg <= 2'd1)
                begin
                    tg = TG_CIRAM;
                    pa = 21'({pg, in_item.addr[9:0]});
                    wr = (in_item.func == FN_NT_WR);
                end
                else if (pg == 2'd2)
                    rram = (in_item.func == FN_NT_RD) && (exram_mode_reg <= 2'd1);
                else if (in_item.func == FN_NT_RD)
                    rd = (in_item.addr[9:0] < 10'h3c0) ? fill_tile_reg : fill_attr_reg;
            end
            FN_TICK:
            begin
                frame_now = (in_item.scanline == 9'd261 || in_item.scanline <= 9'd239)
                            && in_item.render_on;
                if (frame_now && in_item.dot == 9'd0 && line_cnt_reg == irq_cmp_reg
                    && irq_cmp_reg != 8'd0)
                    irq_now = !in_item.irq_masked && irq_en_reg;
            end
            default: ;
        endcase
    end

    // data that comes from the ext RAM read port, taken in ST_MOD
    logic ram_rd_reg;

    always_comb
    begin
        state_next = state_reg;
        res_next   = res_reg;
        res_v_next = res_v_reg;
        if (res_v_reg && out_ready) res_v_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    state_next = ST_MOD;
                    res_next   = '{rdata: rd, target: tg, phys_addr: pa,
                                   ext_write: wr, irq_assert: irq_now};
                end
            end
            ST_MOD:
            begin
                if (ram_rd_reg) res_next.rdata = ram_q;
                if (mod_use_reg)
                    res_next.phys_addr = 21'(moff_reg) + (21'(mod_res) << 13);
                res_v_next = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ext RAM writes (item accept) and clearing pass
    always_comb
    begin
        logic hit;
        hit    = in_valid && in_ready;
        ram_we = 1'b0;
        ram_wa = in_item.addr[XW-1:0];
        ram_wd = in_item.wdata;
        if (clearing)
        begin
            ram_we = 1'b1; ram_wa = clr_reg[XW-1:0]; ram_wd = '0;
        end
        else if (hit && in_item.func == FN_CPU_WR
                 && in_item.addr >= 16'h5c00 && in_item.addr <= 16'h5fff)
        begin
            if (exram_mode_reg == 2'd2) ram_we = 1'b1;
            else if (exram_mode_reg <= 2'd1)
            begin
                ram_we = 1'b1;
                ram_wd = in_item.ppu_rendering ? in_item.wdata : 8'd0;
            end
        end
        else if (hit && in_item.func == FN_NT_WR && pg_is2(in_item.addr))
            ram_we = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mult_a_reg * mult_b_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE; res_v_reg <= 1'b0; res_reg <= '0;
            bank_cnt_reg <= 9'd256; prg_mode_reg <= '0; chr_mode_reg <= '0;
            exram_mode_reg <= '0; chr_upper_reg <= '0;
            ram_prot_reg[0] <= '0; ram_prot_reg[1] <= '0;
            nt_map_reg <= '0; fill_tile_reg <= '0; fill_attr_reg <= '0;
            irq_cmp_reg <= '0;
            for (int i = 0; i < 5; i++) prg_bank_reg[i] <= (i == 4) ? 8'h7f : 8'h00;
            for (int i = 0; i < 12; i++) chr_bank_reg[i] <= '0;
            for (int i = 0; i < 3; i++) split_reg[i] <= '0;
            irq_en_reg <= 1'b0; irq_pend_reg <= 1'b0; in_frame_reg <= 1'b0;
            mult_a_reg <= 8'hff; mult_b_reg <= 8'hff; line_cnt_reg <= 8'hff;
            clr_reg <= '0; mrem_reg <= '0; mod_use_reg <= 1'b0; moff_reg <= '0;
            ram_rd_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            res_reg   <= res_next;
            res_v_reg <= res_v_next;
            if (clearing) clr_reg <= clr_reg + 1'b1;
            if (cfg_we) bank_cnt_reg <= cfg_wdata;
            if (in_valid && in_ready)
            begin
                mrem_reg    <= mrem_next;
                mod_use_reg <= mod_use_next;
                moff_reg    <= moff_next;
                ram_rd_reg  <= rram;
                case (in_item.func)
                    FN_CPU_WR:
                    begin
                        case (in_item.addr)
                            16'h5100: prg_mode_reg   <= in_item.wdata[1:0];
                            16'h5101: chr_mode_reg   <= in_item.wdata[1:0];
                            16'h5102: ram_prot_reg[0] <= in_item.wdata[1:0];
                            16'h5103: ram_prot_reg[1] <= in_item.wdata[1:0];
                            16'h5104: exram_mode_reg <= in_item.wdata[1:0];
                            16'h5105: nt_map_reg     <= in_item.wdata;
                            16'h5106: fill_tile_reg  <= in_item.wdata;
                            16'h5107: fill_attr_reg  <= {4{in_item.wdata[1:0]}};
                            16'h5113: prg_bank_reg[0] <= in_item.wdata & 8'h0f;
                            16'h5114: prg_bank_reg[1] <= in_item.wdata;
                            16'h5115: prg_bank_reg[2] <= in_item.wdata;
                            16'h5116: prg_bank_reg[3] <= in_item.wdata;
                            16'h5117: prg_bank_reg[4] <= in_item.wdata & 8'h7f;
                            16'h5130: chr_upper_reg  <= in_item.wdata[1:0];
                            16'h5200: split_reg[0]   <= in_item.wdata & 8'hdf;
                            16'h5201: split_reg[1]   <= in_item.wdata;
                            16'h5202: split_reg[2]   <= in_item.wdata;
                            16'h5203: irq_cmp_reg    <= in_item.wdata;
                            16'h5204: irq_en_reg     <= in_item.wdata[7];
                            16'h5205: mult_a_reg     <= in_item.wdata;
                            16'h5206: mult_b_reg     <= in_item.wdata;
                            default:
                            begin
                                if (in_item.addr >= 16'h5120 && in_item.addr <= 16'h512b)
                                    chr_bank_reg[4'(in_item.addr[3:0])] <= in_item.wdata;
                            end
                        endcase
                    end
                    FN_RD:
                    begin
                        if (in_item.addr == 16'h5204) irq_pend_reg <= 1'b0;
                    end
                    FN_TICK:
                    begin
                        in_frame_reg <= frame_now;
                        if (!frame_now) line_cnt_reg <= 8'hff;
                        else if (in_item.dot == 9'd0)
                        begin
                            line_cnt_reg <= line_cnt_reg + 8'd1;
                            if (line_cnt_reg == irq_cmp_reg && irq_cmp_reg != 8'd0)
                                irq_pend_reg <= 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end
endmodule

[hw/rtl/cartridge_bank_mapper_with_scanline_irq_core.sv]
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_with_scanline_irq_core
// Cartridge bank mapper with scanline interrupt, stream wrapper.
// ----------------------------------------------------------------------------
// Input items arrive on s_axis (tdata: func, addr, wdata, ppu_rendering,
// tall_sprites, fetching_sprites, scanline, dot, render_on, irq_masked).
// Each item yields one result item on m_axis (tdata: rdata, target,
// phys_addr, ext_write, irq_assert).
// A two-entry queue decouples input from the execute unit. The execute
// unit takes an item, then finishes the ROM bank modulo and takes the
// extended RAM read port data in ST_MOD; a new item is taken once the
// previous result has left the output register.
// After reset the extended RAM is cleared, one entry per cycle, over all
// EXRAM_DEPTH entries; items wait in the queue meanwhile.
// cfg_we/cfg_wdata write the ROM bank count at any edge; write it only
// while idle. A stalled receiver holds the result; the queue then fills
// and s_axis_tready drops.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper_with_scanline_irq_core #(
    parameter int EXRAM_DEPTH = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [8:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // func, addr, wdata, ppu_rendering, tall_sprites, fetching_sprites,
    // scanline, dot, render_on, irq_masked; zero pad to 56 bits
    input  logic [55:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // rdata, target, phys_addr, ext_write, irq_assert; zero pad to 40 bits
    output logic [39:0] m_axis_tdata
);
    import cbm_pkg::*;
    `include "cartridge_bank_mapper_with_scanline_irq_core_macros.svh"

    item_t   in_it, q_it;
    result_t res;
    logic    q_valid, q_ready, clearing;

    assign in_it.func             = s_axis_tdata[2:0];
    assign in_it.addr             = s_axis_tdata[18:3];
    assign in_it.wdata            = s_axis_tdata[26:19];
    assign in_it.ppu_rendering    = s_axis_tdata[27];
    assign in_it.tall_sprites     = s_axis_tdata[28];
    assign in_it.fetching_sprites = s_axis_tdata[29];
    assign in_it.scanline         = s_axis_tdata[38:30];
    assign in_it.dot              = s_axis_tdata[47:39];
    assign in_it.render_on        = s_axis_tdata[48];
    assign in_it.irq_masked       = s_axis_tdata[49];

    cbm_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_item(in_it),
        .out_valid(q_valid), .out_ready(q_ready), .out_item(q_it)
    );

    cbm_exec #(.EXRAM_DEPTH(EXRAM_DEPTH)) u_exec (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(q_valid), .in_ready(q_ready), .in_item(q_it),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_res(res),
        .clearing(clearing)
    );

    assign m_axis_tdata = {6'd0, res.irq_assert, res.ext_write, res.phys_addr,
                           res.target, res.rdata};

    `CBM_ASSERT_NOW(a_no_take_clear, clearing, !q_ready)
    `CBM_ASSERT_NOW(a_irq_no_target, m_axis_tvalid && res.irq_assert,
                    res.target == TG_NONE)
    `CBM_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready,
                     m_axis_tvalid && $stable(m_axis_tdata))
endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Stream-level check of the cartridge bank mapper: bus writes and reads, PRG
// and CHR translation, nametable paging, extended RAM and the scanline IRQ
// are predicted per item and compared with every result item, over several
// ROM bank counts.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import cbm_pkg::*;

    localparam logic [15:0] R_PRG_MODE  = 16'h5100;
    localparam logic [15:0] R_CHR_MODE  = 16'h5101;
    localparam logic [15:0] R_PROT0     = 16'h5102;
    localparam logic [15:0] R_PROT1     = 16'h5103;
    localparam logic [15:0] R_EXRAM     = 16'h5104;
    localparam logic [15:0] R_NT_MAP    = 16'h5105;
    localparam logic [15:0] R_FILL_TILE = 16'h5106;
    localparam logic [15:0] R_FILL_ATTR = 16'h5107;
    localparam logic [15:0] R_PRG_BASE  = 16'h5113;
    localparam logic [15:0] R_CHR_BASE  = 16'h5120;
    localparam logic [15:0] R_CHR_UPPER = 16'h5130;
    localparam logic [15:0] R_SPLIT     = 16'h5200;
    localparam logic [15:0] R_IRQ_CMP   = 16'h5203;
    localparam logic [15:0] R_IRQ_STAT  = 16'h5204;
    localparam logic [15:0] R_MUL_A     = 16'h5205;
    localparam logic [15:0] R_MUL_B     = 16'h5206;
    localparam logic [15:0] EXRAM_BASE  = 16'h5c00;
    localparam logic [15:0] PRAM_BASE   = 16'h6000;
    localparam int          STALL_LIMIT = 5000;

    typedef struct {
        logic [2:0]  func;
        logic [15:0] addr;
        logic [7:0]  wdata;
        logic        rendering;
        logic        tall;
        logic        spr;
        logic [8:0]  line;
        logic [8:0]  dot;
        logic        ron;
        logic        masked;
    } bus_op_t;

    typedef struct packed {
        logic [7:0]  rdata;
        logic [2:0]  target;
        logic [20:0] phys_addr;
        logic        ext_write;
        logic        irq;
    } access_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [8:0]  cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;

    cartridge_bank_mapper_with_scanline_irq_core i_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
    );

    always #6 clk = ~clk;

    // mapper state mirror
    logic [8:0] bank_count;
    logic [1:0] prg_mode, chr_mode, exram_mode;
    logic [7:0] nt_map, fill_tile, fill_attr, irq_cmp, mul_a, mul_b, line_cnt;
    logic [7:0] prg_bank [5];
    logic [7:0] chr_bank [12];
    logic       irq_en, irq_pend, in_frame;
    logic [7:0] exram [1024];

    bus_op_t pending_ops[$];
    access_t expected_accesses[$];
    bus_op_t cur_op;
    logic    op_taken = 1'b0;
    int      send_gap = 0;
    int      recv_gap = 0;
    bit      quiet = 1'b0;
    int      mismatches = 0;
    int      results_seen = 0;
    int      irqs_seen = 0;
    int      idle_cycles = 0;

    function automatic logic [23:0] map_prg(int idx, int lg, logic [15:0] addr);
        logic [7:0]  v;
        logic [8:0]  bank;
        logic [20:0] off;
        v = prg_bank[idx];
        bank = {1'b0, v};
        off = addr & ((21'd1 << lg) - 1);
        if (lg == 15) bank &= 9'hfc;
        else if (lg == 14) bank &= 9'hfe;
        if (idx >= 1 && idx <= 3) begin
            bank &= 9'h7f;
            if (!v[7])
                return {TG_PRAM, off + (21'(bank & 9'hf) << 13)};
        end
        if (bank_count != 0) bank = bank % bank_count;
        return {TG_PROM, off + (21'(bank) << 13)};
    endfunction

    function automatic logic [20:0] map_chr(logic [15:0] addr, logic tall_bg);
        int sz, idx, off, slot, a;
        sz = 'h2000 >> chr_mode;
        if (!tall_bg) begin
            slot = addr / sz;
            idx = (slot + 1) * (8 >> chr_mode) - 1;
            off = addr % sz;
        end else if (chr_mode == 0) begin
            idx = 11;
            off = addr;
        end else begin
            a = addr & 'hfff;
            slot = a / sz;
            idx = 8 + (slot + 1) * (4 >> (chr_mode - 1)) - 1;
            off = a % sz;
        end
        return 21'(chr_bank[idx & 'hf] * sz + off);
    endfunction

    function automatic access_t predict_access(bus_op_t op);
        access_t r;
        logic [23:0] tp;
        logic [9:0]  xi;
        logic [1:0]  page;
        logic [15:0] prod;
        r = '{default: '0};
        xi = op.addr[9:0];
        prod = mul_a * mul_b;
        case (op.func)
            FN_CPU_WR: begin
                if (op.addr == R_PRG_MODE) prg_mode = op.wdata[1:0];
                else if (op.addr == R_CHR_MODE) chr_mode = op.wdata[1:0];
                else if (op.addr == R_EXRAM) exram_mode = op.wdata[1:0];
                else if (op.addr == R_NT_MAP) nt_map = op.wdata;
                else if (op.addr == R_FILL_TILE) fill_tile = op.wdata;
                else if (op.addr == R_FILL_ATTR) fill_attr = op.wdata[1:0] * 8'h55;
                else if (op.addr >= R_PRG_BASE && op.addr <= R_PRG_BASE + 4) begin
                    prg_bank[op.addr - R_PRG_BASE] = (op.addr == R_PRG_BASE) ?
                        (op.wdata & 8'h0f) : (op.addr == R_PRG_BASE + 4) ?
                        (op.wdata & 8'h7f) : op.wdata;
                end else if (op.addr >= R_CHR_BASE && op.addr <= R_CHR_BASE + 11)
                    chr_bank[op.addr - R_CHR_BASE] = op.wdata;
                else if (op.addr == R_IRQ_CMP) irq_cmp = op.wdata;
                else if (op.addr == R_IRQ_STAT) irq_en = op.wdata[7];
                else if (op.addr == R_MUL_A) mul_a = op.wdata;
                else if (op.addr == R_MUL_B) mul_b = op.wdata;
                else if (op.addr >= EXRAM_BASE && op.addr < PRAM_BASE) begin
                    if (exram_mode == 2) exram[xi] = op.wdata;
                    else if (exram_mode <= 1) exram[xi] = op.rendering ? op.wdata : 8'h00;
                end else if (op.addr >= PRAM_BASE && op.addr <= 16'h7fff) begin
                    r.target = TG_PRAM;
                    r.phys_addr = (21'(prg_bank[0]) << 13) + 21'(op.addr - PRAM_BASE);
                    r.ext_write = 1'b1;
                end
            end
            FN_RD: begin
                if (op.addr == R_IRQ_STAT) begin
                    r.rdata = {irq_pend, in_frame, 6'd0};
                    irq_pend = 1'b0;
                end else if (op.addr == R_MUL_A) r.rdata = prod[7:0];
                else if (op.addr == R_MUL_B) r.rdata = prod[15:8];
                else if (op.addr >= EXRAM_BASE && op.addr < PRAM_BASE) begin
                    if (exram_mode >= 2) r.rdata = exram[xi];
                end else if (op.addr >= PRAM_BASE && op.addr <= 16'h7fff) begin
                    r.target = TG_PRAM;
                    r.phys_addr = (21'(prg_bank[0]) << 13) + 21'(op.addr - PRAM_BASE);
                end else if (op.addr >= 16'h8000) begin
                    case (prg_mode)
                        2'd0: tp = map_prg(4, 15, op.addr);
                        2'd1: tp = (op.addr < 16'hc000) ? map_prg(2, 14, op.addr)
                                                        : map_prg(4, 14, op.addr);
                        2'd2: tp = (op.addr < 16'hc000) ? map_prg(2, 14, op.addr) :
                                   (op.addr < 16'he000) ? map_prg(3, 13, op.addr)
                                                        : map_prg(4, 13, op.addr);
                        default: tp = map_prg(1 + op.addr[14:13], 13, op.addr);
                    endcase
                    {r.target, r.phys_addr} = tp;
                end else if (op.addr <= 16'h1fff) begin
                    r.target = TG_CHR;
                    r.phys_addr = map_chr(op.addr, op.tall && !op.spr);
                end
            end
            FN_NT_RD, FN_NT_WR: begin
                page = nt_map >> (op.addr[11:10] * 2);
                if (page <= 1) begin
                    r.target = TG_CIRAM;
                    r.phys_addr = {page, op.addr[9:0]};
                    r.ext_write = (op.func == FN_NT_WR);
                end else if (page == 2) begin
                    if (op.func == FN_NT_WR) exram[xi] = op.wdata;
                    else if (exram_mode <= 1) r.rdata = exram[xi];
                end else if (op.func == FN_NT_RD)
                    r.rdata = (op.addr[9:0] < 10'h3c0) ? fill_tile : fill_attr;
            end
            FN_TICK: begin
                in_frame = (op.line == 261 || op.line <= 239) && op.ron;
                if (op.dot == 0 && in_frame) begin
                    if (line_cnt == irq_cmp && irq_cmp != 0) begin
                        irq_pend = 1'b1;
                        r.irq = !op.masked && irq_en;
                    end
                    line_cnt = line_cnt + 8'd1;
                end
                if (!in_frame) line_cnt = 8'hff;
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic bus_op_t rand_op(logic [2:0] func, logic [15:0] addr);
        bus_op_t op;
        op.func = func;
        op.addr = addr;
        op.wdata = $urandom_range(0, 255);
        {op.rendering, op.tall, op.spr, op.ron, op.masked} = $urandom_range(0, 31);
        op.line = $urandom_range(0, 261);
        op.dot = $urandom_range(0, 340);
        return op;
    endfunction

    function automatic bus_op_t wr_op(logic [15:0] addr, logic [7:0] data);
        bus_op_t op;
        op = rand_op(FN_CPU_WR, addr);
        op.wdata = data;
        return op;
    endfunction

    // random access, weighted toward mapped regions
    function automatic bus_op_t any_op();
        int sel;
        logic [15:0] a;
        sel = $urandom_range(0, 99);
        if (sel < 12) a = R_PRG_MODE + $urandom_range(0, 7);
        else if (sel < 20) a = R_PRG_BASE + $urandom_range(0, 4);
        else if (sel < 28) a = R_CHR_BASE + $urandom_range(0, 16);
        else if (sel < 36) a = R_SPLIT + $urandom_range(0, 6);
        else if (sel < 48) a = EXRAM_BASE + $urandom_range(0, 'h3ff);
        else if (sel < 56) a = PRAM_BASE + $urandom_range(0, 'h1fff);
        else if (sel < 72) a = $urandom_range('h8000, 'hffff);
        else if (sel < 86) a = $urandom_range(0, 'h1fff);
        else a = $urandom_range(0, 'hffff);
        return rand_op($urandom_range(0, 1) ? FN_CPU_WR : FN_RD, a);
    endfunction

    // interrupt setup followed by a run of scanline starts and a status read
    task automatic queue_frame();
        bus_op_t op;
        int cmp;
        cmp = $urandom_range(0, 12);
        pending_ops.push_back(wr_op(R_IRQ_CMP, cmp));
        pending_ops.push_back(wr_op(R_IRQ_STAT, {$urandom_range(0, 3) != 0, 7'd0}));
        for (int ln = 0; ln < cmp + 3; ln++) begin
            op = rand_op(FN_TICK, $urandom_range(0, 'hffff));
            op.line = (ln == 0) ? 9'd261 : 9'(ln - 1);
            op.dot = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 340) : 0;
            op.ron = ($urandom_range(0, 15) != 0);
            op.masked = ($urandom_range(0, 3) == 0);
            pending_ops.push_back(op);
        end
        pending_ops.push_back(rand_op(FN_RD, R_IRQ_STAT));
    endtask

    task automatic write_bank_count(logic [8:0] v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        bank_count = v;
    endtask

    task automatic drain();
        wait (pending_ops.size() == 0 && !s_axis_tvalid && expected_accesses.size() == 0);
        repeat (8) @(negedge clk);
    endtask

    // input side
    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || op_taken))
        begin
            if (send_gap > 0 && !quiet)
            begin
                s_axis_tvalid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (pending_ops.size() > 0)
            begin
                cur_op = pending_ops.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {6'd0, cur_op.masked, cur_op.ron, cur_op.dot, cur_op.line,
                                 cur_op.spr, cur_op.tall, cur_op.rendering, cur_op.wdata,
                                 cur_op.addr, cur_op.func};
                if ($urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 9);
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // output side backpressure
    always @(negedge clk)
    begin
        if (quiet)
            m_axis_tready <= 1'b1;
        else if (recv_gap > 0)
        begin
            m_axis_tready <= 1'b0;
            recv_gap <= recv_gap - 1;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 7) == 0) recv_gap <= $urandom_range(1, 9);
        end
    end

    always @(posedge clk)
    begin
        access_t got, want;
        op_taken <= s_axis_tvalid && s_axis_tready;
        if (s_axis_tvalid && s_axis_tready)
            expected_accesses.push_back(predict_access(cur_op));
        if (m_axis_tvalid && m_axis_tready)
        begin
            got.rdata = m_axis_tdata[7:0];
            got.target = m_axis_tdata[10:8];
            got.phys_addr = m_axis_tdata[31:11];
            got.ext_write = m_axis_tdata[32];
            got.irq = m_axis_tdata[33];
            results_seen++;
            if (got.irq) irqs_seen++;
            if (expected_accesses.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result item %h", m_axis_tdata);
            end
            else
            begin
                want = expected_accesses.pop_front();
                if (got != want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("item %0d: exp rd=%h tg=%0d pa=%h wr=%b irq=%b, got rd=%h tg=%0d pa=%h wr=%b irq=%b",
                                 results_seen, want.rdata, want.target, want.phys_addr,
                                 want.ext_write, want.irq, got.rdata, got.target,
                                 got.phys_addr, got.ext_write, got.irq);
                end
            end
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (rst_n)
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        int counts[5];
        bus_op_t op;
        counts = '{256, 1, 0, 37, 256};
        prg_mode = 0; chr_mode = 0; exram_mode = 0;
        nt_map = 0; fill_tile = 0; fill_attr = 0; irq_cmp = 0;
        mul_a = 8'hff; mul_b = 8'hff; line_cnt = 8'hff;
        irq_en = 0; irq_pend = 0; in_frame = 0;
        bank_count = 9'd256;
        foreach (prg_bank[i]) prg_bank[i] = 0;
        prg_bank[4] = 8'h7f;
        foreach (chr_bank[i]) chr_bank[i] = 0;
        foreach (exram[i]) exram[i] = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: register extremes, multiplier, paging, fill, ext RAM, PRG and CHR cases
        write_bank_count(9'd256);
        pending_ops.push_back(rand_op(FN_RD, R_MUL_A));
        pending_ops.push_back(rand_op(FN_RD, R_MUL_B));
        pending_ops.push_back(rand_op(FN_RD, 16'hffff));
        pending_ops.push_back(wr_op(R_PROT0, 8'hff));
        pending_ops.push_back(wr_op(R_PROT1, 8'h00));
        pending_ops.push_back(wr_op(R_CHR_UPPER, 8'hff));
        pending_ops.push_back(wr_op(R_SPLIT, 8'hff));
        pending_ops.push_back(wr_op(R_NT_MAP, 8'he4));
        pending_ops.push_back(wr_op(R_FILL_TILE, 8'hff));
        pending_ops.push_back(wr_op(R_FILL_ATTR, 8'h03));
        pending_ops.push_back(rand_op(FN_NT_RD, 16'hfc00));
        pending_ops.push_back(rand_op(FN_NT_RD, 16'h2fbf));
        pending_ops.push_back(rand_op(FN_NT_WR, 16'h2bff));
        pending_ops.push_back(rand_op(FN_NT_RD, 16'h0bff));
        pending_ops.push_back(rand_op(FN_NT_WR, 16'h2400));
        pending_ops.push_back(wr_op(R_EXRAM, 8'h02));
        pending_ops.push_back(wr_op(16'h5fff, 8'ha5));
        pending_ops.push_back(rand_op(FN_RD, 16'h5fff));
        pending_ops.push_back(wr_op(R_PRG_BASE + 2, 8'hff));
        pending_ops.push_back(rand_op(FN_RD, 16'h8000));
        pending_ops.push_back(wr_op(R_PRG_MODE, 8'h03));
        pending_ops.push_back(rand_op(FN_RD, 16'hffff));
        pending_ops.push_back(wr_op(R_CHR_MODE, 8'h03));
        pending_ops.push_back(rand_op(FN_RD, 16'h1fff));
        pending_ops.push_back(wr_op(PRAM_BASE + 16'h1fff, 8'h5a));
        drain();

        for (int ph = 0; ph < 5; ph++)
        begin
            write_bank_count(counts[ph] == 37 ? $urandom_range(2, 255) : counts[ph]);
            quiet = (ph == 4);
            for (int n = 0; n < 100; n++)
            begin
                case ($urandom_range(0, 9))
                    0: queue_frame();
                    1, 2: pending_ops.push_back(rand_op($urandom_range(2, 3),
                                                        $urandom_range(0, 'hffff)));
                    3: pending_ops.push_back(rand_op(FN_TICK, $urandom_range(0, 'hffff)));
                    default: pending_ops.push_back(any_op());
                endcase
            end
            drain();
        end

        $display("checked %0d result items across five ROM bank counts, %0d interrupts raised",
                 results_seen, irqs_seen);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
